// ===== design/bsb_pkg.sv =====
// shared constants for the b-spline basis evaluator
// no dependencies; used by bsb_div and bspline_basis_eval
package bsb_pkg;

   localparam int MAX_KNOTS  = 16;
   localparam int KNOT_AW    = 4;
   localparam int KNOT_CW    = 5;
   localparam int KNOT_W     = 32;
   localparam int BASIS_W    = 17;
   localparam int DIVIDEND_W = 51;
   localparam int DIVISOR_W  = 33;
   localparam int QUOT_W     = 52;
   localparam int STEP_W     = 6;

   localparam logic [BASIS_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam logic [1:0] CSR_DEGREE     = 2'd0;
   localparam logic [1:0] CSR_KNOT_COUNT = 2'd1;

endpackage

// ===== design/bspline_basis_eval.sv =====
// Cox-de Boor basis evaluator: a knot write (op 0) is taken while idle; an evaluation
// (op 1) builds the degree-0 row one knot span at a time, then each term of each
// higher level whose lower basis and knot span are nonzero goes through one serial
// divider, and then the results are emitted (an error result if the knot count is
// under degree + 2). The knot table and the working basis row sit in two 16-entry
// memories with registered reads; one transaction is worked at a time.
// depends on bsb_pkg and bsb_div
module bspline_basis_eval (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [3:0]           req_knot_index,
   input  logic signed [31:0]   req_knot_value,
   input  logic signed [31:0]   req_point,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_basis_index,
   output logic [16:0]          rsp_basis_value,
   output logic                 rsp_last,
   output logic                 rsp_config_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_D0_RD = 4'd1;
   localparam logic [3:0] S_D0_WR = 4'd2;
   localparam logic [3:0] S_LV_R1 = 4'd3;
   localparam logic [3:0] S_LV_R2 = 4'd4;
   localparam logic [3:0] S_LV_MA = 4'd5;
   localparam logic [3:0] S_LV_DA = 4'd6;
   localparam logic [3:0] S_LV_MB = 4'd7;
   localparam logic [3:0] S_LV_DB = 4'd8;
   localparam logic [3:0] S_EM_RD = 4'd9;
   localparam logic [3:0] S_EM_WR = 4'd10;
   localparam logic [3:0] S_ERR   = 4'd11;

   logic [3:0]                        state_ff, state_in;
   logic [1:0]                        degree_ff, degree_in;
   logic [bsb_pkg::KNOT_CW-1:0]       kc_ff, kc_in;
   logic [bsb_pkg::KNOT_CW-1:0]       kc_eff;
   logic [bsb_pkg::KNOT_CW-1:0]       j_ff, j_in;
   logic [1:0]                        r_ff, r_in;
   logic signed [31:0]                x_ff, x_in;
   logic signed [31:0]                tj_ff, tj_in, tjr_ff, tjr_in;
   logic signed [31:0]                tj1_ff, tj1_in, tjr1_ff, tjr1_in;
   logic [bsb_pkg::BASIS_W-1:0]       nj_ff, nj_in, nj1_ff, nj1_in;
   logic signed [bsb_pkg::DIVIDEND_W-1:0] prod_ff, prod_in;
   logic signed [bsb_pkg::DIVISOR_W-1:0]  span_ff, span_in;
   logic                              skip_ff, skip_in;
   logic                              pend_ff, pend_in;
   logic signed [bsb_pkg::QUOT_W-1:0] a_ff, a_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [3:0]                        rsp_index_ff, rsp_index_in;
   logic [bsb_pkg::BASIS_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_err_ff, rsp_err_in;

   logic signed [31:0]                knot_mem [bsb_pkg::MAX_KNOTS];
   logic [bsb_pkg::BASIS_W-1:0]       basis_mem [bsb_pkg::MAX_KNOTS];
   logic signed [31:0]                kq0_ff, kq1_ff;
   logic [bsb_pkg::BASIS_W-1:0]       bq0_ff, bq1_ff;
   logic [bsb_pkg::KNOT_AW-1:0]       ka0, ka1, ba0, ba1, bwa;
   logic [bsb_pkg::KNOT_CW-1:0]       ka0_w, ka1_w;
   logic                              bwe;
   logic [bsb_pkg::BASIS_W-1:0]       bwd;
   logic                              kwe;

   logic                              div_start;
   logic                              div_done;
   logic signed [bsb_pkg::QUOT_W-1:0] div_q;
   logic signed [bsb_pkg::QUOT_W:0]   sum;
   logic [bsb_pkg::BASIS_W-1:0]       sat;
   logic                              rsp_free;
   logic [bsb_pkg::KNOT_CW-1:0]       nb;
   logic [bsb_pkg::KNOT_CW-1:0]       cnt_lv;
   logic signed [32:0]                num;
   logic [bsb_pkg::BASIS_W-1:0]       lower;
   logic signed [bsb_pkg::DIVIDEND_W-1:0] prod_w;

   bsb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign kc_eff   = (kc_ff > bsb_pkg::KNOT_CW'(bsb_pkg::MAX_KNOTS))
                     ? bsb_pkg::KNOT_CW'(bsb_pkg::MAX_KNOTS) : kc_ff;
   assign nb       = kc_eff - 1'b1 - bsb_pkg::KNOT_CW'(degree_ff);
   assign cnt_lv   = kc_eff - 1'b1 - bsb_pkg::KNOT_CW'(r_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign kwe      = req_valid && req_ready && (req_op == bsb_pkg::OP_WRITE);

   // knot reads: t[j],t[j+1] in degree 0; t[j],t[j+r] then t[j+1],t[j+r+1] in levels
   always_comb begin
      ka0_w = j_ff;
      ka1_w = j_ff + bsb_pkg::KNOT_CW'(r_ff);
      if (state_ff == S_D0_RD) begin
         ka1_w = j_ff + 1'b1;
      end else if (state_ff == S_LV_R2) begin
         ka0_w = j_ff + 1'b1;
         ka1_w = j_ff + bsb_pkg::KNOT_CW'(r_ff) + 1'b1;
      end
   end
   assign ka0 = ka0_w[bsb_pkg::KNOT_AW-1:0];
   assign ka1 = ka1_w[bsb_pkg::KNOT_AW-1:0];
   assign ba0 = j_ff[bsb_pkg::KNOT_AW-1:0];
   assign ba1 = bsb_pkg::KNOT_AW'(j_ff + 1'b1);
   assign bwa = j_ff[bsb_pkg::KNOT_AW-1:0];

   always_ff @(posedge clock) begin
      if (kwe) begin
         knot_mem[req_knot_index] <= req_knot_value;
      end
      kq0_ff <= knot_mem[ka0];
      kq1_ff <= knot_mem[ka1];
   end

   always_ff @(posedge clock) begin
      if (bwe) begin
         basis_mem[bwa] <= bwd;
      end
      bq0_ff <= basis_mem[ba0];
      bq1_ff <= basis_mem[ba1];
   end

   function automatic logic signed [bsb_pkg::QUOT_W:0] QUOT_EXT(
      input logic signed [bsb_pkg::QUOT_W-1:0] v);
      QUOT_EXT = {v[bsb_pkg::QUOT_W-1], v};
   endfunction

   assign sum = QUOT_EXT(a_ff) + QUOT_EXT(div_q);

   always_comb begin
      if (sum < 0) begin
         sat = '0;
      end else if (sum > $signed({{(bsb_pkg::QUOT_W - bsb_pkg::BASIS_W + 1){1'b0}},
                                  bsb_pkg::ONE_Q16})) begin
         sat = bsb_pkg::ONE_Q16;
      end else begin
         sat = sum[bsb_pkg::BASIS_W-1:0];
      end
   end

   // term operands: first term in MA, second in MB
   always_comb begin
      if (state_ff == S_LV_MA) begin
         num   = {x_ff[31], x_ff} - {tj_ff[31], tj_ff};
         lower = nj_ff;
      end else begin
         num   = {tjr1_ff[31], tjr1_ff} - {x_ff[31], x_ff};
         lower = nj1_ff;
      end
   end

   assign prod_w = $signed({{(bsb_pkg::DIVIDEND_W - 33){num[32]}}, num})
                 * $signed({{(bsb_pkg::DIVIDEND_W - bsb_pkg::BASIS_W){1'b0}}, lower});

   always_comb begin
      state_in     = state_ff;
      degree_in    = degree_ff;
      kc_in        = kc_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      tj_in        = tj_ff;
      tjr_in       = tjr_ff;
      tj1_in       = tj1_ff;
      tjr1_in      = tjr1_ff;
      nj_in        = nj_ff;
      nj1_in       = nj1_ff;
      prod_in      = prod_ff;
      span_in      = span_ff;
      skip_in      = skip_ff;
      pend_in      = pend_ff;
      a_in         = a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      bwe          = 1'b0;
      bwd          = '0;
      div_start    = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsb_pkg::CSR_DEGREE:     degree_in = csr_wdata[1:0];
            bsb_pkg::CSR_KNOT_COUNT: kc_in     = csr_wdata[bsb_pkg::KNOT_CW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_op == bsb_pkg::OP_EVAL) begin
               x_in = req_point;
               j_in = '0;
               r_in = 2'd1;
               if (bsb_pkg::KNOT_CW'(degree_ff) + 2'd2 > kc_eff) begin
                  state_in = S_ERR;
               end else begin
                  state_in = S_D0_RD;
               end
            end
         end
         S_D0_RD: state_in = S_D0_WR;
         S_D0_WR: begin
            bwe = 1'b1;
            bwd = (x_ff >= kq0_ff && x_ff < kq1_ff) ? bsb_pkg::ONE_Q16 : '0;
            j_in = j_ff + 1'b1;
            if (j_ff + 2'd2 < kc_eff) begin
               state_in = S_D0_RD;
            end else begin
               j_in     = '0;
               state_in = (degree_ff == 2'd0) ? S_EM_RD : S_LV_R1;
            end
         end
         S_LV_R1: state_in = S_LV_R2;
         S_LV_R2: begin
            tj_in    = kq0_ff;
            tjr_in   = kq1_ff;
            nj_in    = bq0_ff;
            nj1_in   = bq1_ff;
            state_in = S_LV_MA;
         end
         S_LV_MA: begin
            tj1_in   = kq0_ff;
            tjr1_in  = kq1_ff;
            prod_in  = prod_w;
            span_in  = {tjr_ff[31], tjr_ff} - {tj_ff[31], tj_ff};
            skip_in  = (lower == '0) || (tjr_ff == tj_ff);
            pend_in  = 1'b0;
            state_in = S_LV_DA;
         end
         S_LV_DA: begin
            if (skip_ff) begin
               a_in     = '0;
               state_in = S_LV_MB;
            end else if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               a_in     = div_q;
               state_in = S_LV_MB;
            end
         end
         S_LV_MB: begin
            prod_in  = prod_w;
            span_in  = {tjr1_ff[31], tjr1_ff} - {tj1_ff[31], tj1_ff};
            skip_in  = (nj1_ff == '0) || (tjr1_ff == tj1_ff);
            pend_in  = 1'b0;
            state_in = S_LV_DB;
         end
         S_LV_DB: begin
            if (skip_ff || (pend_ff && div_done)) begin
               bwe = 1'b1;
               if (skip_ff) begin
                  if (a_ff < 0) begin
                     bwd = '0;
                  end else if (a_ff > $signed({{(bsb_pkg::QUOT_W - bsb_pkg::BASIS_W){1'b0}},
                                               bsb_pkg::ONE_Q16})) begin
                     bwd = bsb_pkg::ONE_Q16;
                  end else begin
                     bwd = a_ff[bsb_pkg::BASIS_W-1:0];
                  end
               end else begin
                  bwd = sat;
               end
               j_in = j_ff + 1'b1;
               state_in = S_LV_R1;
               if (j_ff + 1'b1 >= cnt_lv) begin
                  j_in = '0;
                  r_in = r_ff + 1'b1;
                  if (r_ff == degree_ff) begin
                     state_in = S_EM_RD;
                  end
               end
            end else if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end
         end
         S_EM_RD: state_in = S_EM_WR;
         S_EM_WR: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = j_ff[3:0];
               rsp_value_in = bq0_ff;
               rsp_last_in  = (j_ff + 1'b1 == nb);
               rsp_err_in   = 1'b0;
               j_in         = j_ff + 1'b1;
               state_in     = (j_ff + 1'b1 == nb) ? S_IDLE : S_EM_RD;
            end
         end
         S_ERR: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         degree_ff    <= 2'd1;
         kc_ff        <= 5'd6;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         degree_ff    <= degree_in;
         kc_ff        <= kc_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      j_ff         <= j_in;
      r_ff         <= r_in;
      x_ff         <= x_in;
      tj_ff        <= tj_in;
      tjr_ff       <= tjr_in;
      tj1_ff       <= tj1_in;
      tjr1_ff      <= tjr1_in;
      nj_ff        <= nj_in;
      nj1_ff       <= nj1_in;
      prod_ff      <= prod_in;
      span_ff      <= span_in;
      skip_ff      <= skip_in;
      a_ff         <= a_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_basis_index  = rsp_index_ff;
   assign rsp_basis_value  = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_config_error = rsp_err_ff;

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff && rsp_value_ff == '0)
      else $error("error transaction not a single zero result");

   a_value_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_value_ff <= bsb_pkg::ONE_Q16)
      else $error("basis value above one");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EM_WR && rsp_free |=> rsp_valid_ff)
      else $error("emitted result lost");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> state_ff == S_LV_DA || state_ff == S_LV_DB)
      else $error("divider started outside a term step");

endmodule

// ===== design/bsb_div.sv =====
// serial signed divider, one quotient bit per cycle, truncates toward zero
// depends on bsb_pkg
module bsb_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [bsb_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic signed [bsb_pkg::DIVISOR_W-1:0]   divisor,
   output logic                                   done,
   output logic signed [bsb_pkg::QUOT_W-1:0]      quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;
   logic [bsb_pkg::STEP_W-1:0]        cnt_ff, cnt_in;
   logic [bsb_pkg::DIVISOR_W:0]       rem_ff, rem_in;
   logic [bsb_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [bsb_pkg::DIVISOR_W-1:0]     den_ff, den_in;
   logic [bsb_pkg::DIVISOR_W:0]       shifted;
   logic [bsb_pkg::DIVISOR_W:0]       diff;
   logic                              fits;

   assign shifted = {rem_ff[bsb_pkg::DIVISOR_W-1:0], quo_ff[bsb_pkg::DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[bsb_pkg::DIVIDEND_W-1] ^ divisor[bsb_pkg::DIVISOR_W-1];
         cnt_in  = bsb_pkg::STEP_W'(bsb_pkg::DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = dividend[bsb_pkg::DIVIDEND_W-1] ? -dividend : dividend;
         den_in  = divisor[bsb_pkg::DIVISOR_W-1] ? -divisor : divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff : shifted;
         quo_in = {quo_ff[bsb_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule
